// ===== rtl/kmdne_pkg.sv =====
`default_nettype none
package kmdne_pkg;

	localparam int ROWS_DEF = 4;
	localparam int COLS_DEF = 4;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEBOUNCE_MS      = 2'd0,
		CFG_SCAN_INTERVAL_MS = 2'd1,
		CFG_ROOT_NOTE        = 2'd2
	} cfg_reg_t;

	localparam logic [15:0] DEBOUNCE_MS_RST      = 16'd20;
	localparam logic [7:0]  SCAN_INTERVAL_MS_RST = 8'd5;
	localparam logic [6:0]  ROOT_NOTE_RST        = 7'd60;

	localparam logic [7:0] NOTE_ON_STATUS  = 8'h90;
	localparam logic [7:0] NOTE_OFF_STATUS = 8'h80;
	localparam logic [6:0] FULL_VELOCITY   = 7'd127;

	// controller -> datapath
	typedef struct packed {
		logic load;   // latch an accepted scan and restart the key walk
		logic step;   // commit the current key and advance
		logic flush;  // send the held event as the last one of the scan
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic early;      // incoming scan is inside the scan interval
		logic key_event;  // current key produces an event
		logic pend_valid; // an event is held back waiting for its successor
		logic out_free;   // output register can take a beat this cycle
		logic last_key;   // current key is the last of the matrix
	} ctl_sts_t;

endpackage
`default_nettype wire

// ===== rtl/kmdne_if.sv =====
`default_nettype none
interface kmdne_scan_if;
	logic        valid;
	logic        ready;
	logic [31:0] now_ms;
	logic [15:0] row_bits;
	logic        host_ready;

	modport source (output valid, now_ms, row_bits, host_ready, input ready);
	modport sink   (input valid, now_ms, row_bits, host_ready, output ready);
endinterface

interface kmdne_note_if;
	logic       valid;
	logic       ready;
	logic [7:0] status_byte;
	logic [6:0] note_number;
	logic [6:0] velocity;
	logic       last_event;

	modport source (output valid, status_byte, note_number, velocity, last_event, input ready);
	modport sink   (input valid, status_byte, note_number, velocity, last_event, output ready);
endinterface
`default_nettype wire

// ===== rtl/kmdne_dp.sv =====
`default_nettype none
module kmdne_dp #(
	parameter int ROWS = kmdne_pkg::ROWS_DEF,
	parameter int COLS = kmdne_pkg::COLS_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  kmdne_pkg::ctl_cmd_t                  cmd,
	output kmdne_pkg::ctl_sts_t                  sts,
	input  wire                                  cfg_we,
	input  wire  [kmdne_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [kmdne_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire  [31:0]                          in_now_ms,
	input  wire  [15:0]                          in_row_bits,
	input  wire                                  in_host_ready,
	input  wire                                  out_ready,
	output logic                                 out_valid,
	output logic [7:0]                           out_status_byte,
	output logic [6:0]                           out_note_number,
	output logic [6:0]                           out_velocity,
	output logic                                 out_last_event
);
	import kmdne_pkg::*;

	localparam int KEYS  = ROWS * COLS;
	localparam int KEY_W = (KEYS > 1) ? $clog2(KEYS) : 1;
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int COL_W = (COLS > 1) ? $clog2(COLS) : 1;

	logic [15:0] debounce_q;
	logic [7:0]  interval_q;
	logic [6:0]  base_q;

	logic [31:0] last_scan_q;
	logic [KEYS-1:0] key_pressed_q;
	logic [31:0] change_time_q [KEYS];

	logic [31:0] now_q;
	logic [15:0] bits_q;
	logic        host_q;

	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic [KEY_W-1:0] key_q;

	logic       pend_valid_q;
	logic       pend_on_q;
	logic [6:0] pend_note_q;

	logic       out_valid_q;
	logic       out_on_q;
	logic [6:0] out_note_q;
	logic       out_last_q;

	logic [4:0]  bit_idx;
	logic        lvl;
	logic [31:0] elapsed;
	logic        changed;
	logic        key_event;
	logic [6:0]  note;
	logic        out_free;
	logic        push;

	// key (row, col) is sampled at bit col*4+row; bits past the field read released
	assign bit_idx   = {3'(col_q), 2'b00} + 5'(row_q);
	assign lvl       = (bit_idx < 5'd16) ? ~bits_q[bit_idx[3:0]] : 1'b0;
	assign elapsed   = now_q - change_time_q[key_q];
	assign changed   = (lvl != key_pressed_q[key_q]) && (elapsed > {16'b0, debounce_q});
	assign key_event = changed && host_q;
	assign note      = base_q + 7'({row_q, 2'b00}) + 7'(col_q);
	assign out_free  = !out_valid_q || out_ready;
	assign push      = (cmd.step && key_event && pend_valid_q) || cmd.flush;

	always_comb begin
		sts.early      = (in_now_ms - last_scan_q) < {24'b0, interval_q};
		sts.key_event  = key_event;
		sts.pend_valid = pend_valid_q;
		sts.out_free   = out_free;
		sts.last_key   = (row_q == ROW_W'(ROWS - 1)) && (col_q == COL_W'(COLS - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_MS_RST;
			interval_q <= SCAN_INTERVAL_MS_RST;
			base_q     <= ROOT_NOTE_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_DEBOUNCE_MS:      debounce_q <= cfg_data;
				CFG_SCAN_INTERVAL_MS: interval_q <= cfg_data[7:0];
				CFG_ROOT_NOTE:        base_q     <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_scan_q   <= '0;
			key_pressed_q <= '0;
			for (int k = 0; k < KEYS; k++) begin
				change_time_q[k] <= '0;
			end
			row_q        <= '0;
			col_q        <= '0;
			key_q        <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				last_scan_q <= in_now_ms;
				row_q       <= '0;
				col_q       <= '0;
				key_q       <= '0;
			end
			if (cmd.step) begin
				if (changed) begin
					key_pressed_q[key_q] <= lvl;
					change_time_q[key_q] <= now_q;
				end
				key_q <= key_q + 1'b1;
				if (col_q == COL_W'(COLS - 1)) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
			if (cmd.step && key_event) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.flush) begin
				pend_valid_q <= 1'b0;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			now_q  <= in_now_ms;
			bits_q <= in_row_bits;
			host_q <= in_host_ready;
		end
		if (cmd.step && key_event) begin
			pend_on_q   <= lvl;
			pend_note_q <= note;
		end
		// held event goes out once its successor is known, or at the end of the walk
		if (push) begin
			out_on_q   <= pend_on_q;
			out_note_q <= pend_note_q;
			out_last_q <= cmd.flush;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_status_byte = out_on_q ? NOTE_ON_STATUS : NOTE_OFF_STATUS;
	assign out_note_number = out_note_q;
	assign out_velocity    = out_on_q ? FULL_VELOCITY : 7'd0;
	assign out_last_event  = out_last_q;

endmodule
`default_nettype wire

// ===== rtl/kmdne_ctrl.sv =====
`default_nettype none
module kmdne_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  kmdne_pkg::ctl_sts_t  sts,
	output kmdne_pkg::ctl_cmd_t  cmd
);
	import kmdne_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FLUSH
	} state_t;

	state_t state_q;
	logic   stall;

	assign in_ready = (state_q == ST_IDLE);
	// a new event must push the held one out; wait while the output is occupied
	assign stall    = sts.key_event && sts.pend_valid && !sts.out_free;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:  cmd.load  = in_valid && !sts.early;
			ST_WALK:  cmd.step  = !stall;
			ST_FLUSH: cmd.flush = sts.pend_valid && sts.out_free;
			default:  cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.load) state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (cmd.step && sts.last_key) state_q <= ST_FLUSH;
				end
				ST_FLUSH: begin
					if (!sts.pend_valid || sts.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/key_matrix_debounce_note_events_unit.sv =====
`default_nettype none
// Matrix key scanner with per-key debounce. Each beat on "in" is one full scan
// of a ROWS x COLS matrix (active-low levels, key (row, col) at bit col*4+row)
// with a millisecond timestamp. A scan arriving less than scan_interval_ms after
// the last taken scan is accepted and dropped. A taken scan walks the keys one
// per cycle in row-major order, pausing while the output is stalled, through a
// single compare/update unit. The scan is taken, each key is compared in turn,
// and a closing step sends the last held beat, if any; only after that is "in"
// ready again, so it is ready only between scans. Each key whose level changed
// and whose last change is more than debounce_ms old flips state and, with
// host_ready set, produces a note-on/note-off beat on "out"; last_event marks
// the final beat of a scan. Per-key state resets with the block; there is no
// clearing pass. Register writes belong between scans.
module key_matrix_debounce_note_events_unit #(
	parameter int ROWS = kmdne_pkg::ROWS_DEF,
	parameter int COLS = kmdne_pkg::COLS_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               cfg_we,
	input  wire [kmdne_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [kmdne_pkg::CFG_DATA_W-1:0]   cfg_data,
	kmdne_scan_if.sink                        in,
	kmdne_note_if.source                      out
);
	import kmdne_pkg::*;

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	kmdne_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in.valid),
		.in_ready (in.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	kmdne_dp #(
		.ROWS (ROWS),
		.COLS (COLS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_now_ms       (in.now_ms),
		.in_row_bits     (in.row_bits),
		.in_host_ready   (in.host_ready),
		.out_ready       (out.ready),
		.out_valid       (out.valid),
		.out_status_byte (out.status_byte),
		.out_note_number (out.note_number),
		.out_velocity    (out.velocity),
		.out_last_event  (out.last_event)
	);

endmodule
`default_nettype wire
